// ----- hdl/crse_pkg.sv -----
// ----------------------------------------------------------------------------
// crse_pkg: shared types, constants and helpers
// Point layout, sequencer states, datapath widths and rounding/saturation
// functions for the Catmull-Rom spline evaluator.
// ----------------------------------------------------------------------------
package crse_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MIDX_W     = $clog2(MAX_POINTS);
  localparam int NW         = $clog2(MAX_POINTS + 1);
  localparam int T_W        = 17;
  localparam int OW         = 40;           // multiplier operand width
  localparam int PW         = OW + T_W + 1; // product width
  localparam int SC_W       = T_W + NW;     // t * segments

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  // register indexes
  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_CLOSED_LOOP = 2'd1;
  localparam logic [1:0] REG_INTERP_MODE = 2'd2;

  // sample kinds
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_CURVE  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] roll;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_SPLIT,
    ST_FETCH,
    ST_CALC,
    ST_EMIT
  } state_t;

  // floor(p / 2^16 + 1/2)
  function automatic logic signed [OW-1:0] rnd16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] w;
    w = p + PW'(32768);
    return w[16 +: OW];
  endfunction

  // floor(v / 2 + 1/2)
  function automatic logic signed [OW:0] rnd1(input logic signed [OW:0] v);
    logic signed [OW:0] w;
    w = v + (OW+1)'(1);
    return w >>> 1;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [OW:0] v);
    if (v > (OW+1)'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -(OW+1)'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [OW:0] v);
    if (v > (OW+1)'(32767)) return 16'sh7FFF;
    if (v < -(OW+1)'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ----- hdl/crse_store.sv -----
// ----------------------------------------------------------------------------
// crse_store: control point memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crse_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [crse_pkg::MIDX_W-1:0] waddr,
  input  crse_pkg::point_t           wdata,
  input  logic [crse_pkg::MIDX_W-1:0] raddr,
  output crse_pkg::point_t           rdata
);

  crse_pkg::point_t mem [crse_pkg::MAX_POINTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/crse_mul.sv -----
// ----------------------------------------------------------------------------
// crse_mul: shared multiplier
// Signed operand times unsigned local t, product registered.
// ----------------------------------------------------------------------------
module crse_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [crse_pkg::OW-1:0]    op,
  input  logic [crse_pkg::T_W-1:0]          t,
  output logic signed [crse_pkg::PW-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op * $signed({1'b0, t});
    end
  end

endmodule

// ----- hdl/catmull_rom_spline_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_spline_evaluator_core: uniform Catmull-Rom spline evaluator
// Point store, segment split, four point fetches and a sequencer that runs
// the cubic on one shared multiplier, axis by axis.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | func, point_index, point_*, curve_t
//  out     | out_valid / out_ready| sample_kind, pos_*, tan_*, roll_out,...
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// A write word is stored on acceptance. An evaluate word keeps the
// sequencer busy: with no points it goes straight to emit; else it splits
// t into segment and local t, runs the four point fetches and, with two or
// more points, does five products and a finish step per cubic axis, or one
// per linear axis and roll, then emits; in_ready rises as the result loads.
// Reset clears control state and config; the point store is not cleared.
// A new word is taken while a finished result waits; the result stage
// stalls the sequencer only when a second result is ready before the first
// is taken.
// ----------------------------------------------------------------------------
module catmull_rom_spline_evaluator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] point_roll,
  input  logic [16:0]        curve_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         sample_kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] tan_x,
  output logic signed [31:0] tan_y,
  output logic signed [31:0] tan_z,
  output logic signed [15:0] roll_out,
  output logic [5:0]         segment_out,
  output logic [16:0]        local_t_out
);

  localparam int OW = crse_pkg::OW;
  localparam int NW = crse_pkg::NW;
  localparam int MW = crse_pkg::MIDX_W;

  // config registers
  logic [6:0] point_count;
  logic       closed_loop;
  logic       interp_mode;

  crse_pkg::state_t state, state_next;

  logic [crse_pkg::T_W-1:0]  t_reg;
  logic [NW-1:0]             n_reg;
  logic [crse_pkg::SC_W-1:0] scaled;
  logic [NW-1:0]             seg;
  logic [crse_pkg::T_W-1:0]  lt;
  logic [2:0]                fk;
  crse_pkg::point_t          pts [4];
  logic [1:0]                ax;
  logic [3:0]                s;
  logic signed [OW-1:0]      op;
  logic signed [OW-1:0]      hsave;
  logic signed [31:0]        res_pos [3];
  logic signed [31:0]        res_tan [3];
  logic signed [15:0]        res_roll;

  logic                      in_acc, eval_acc, emit_go, calc_fin;
  logic [NW-1:0]             n_in, segs;
  logic [MW-1:0]             raddr;
  crse_pkg::point_t          rdata, wdata;
  logic                      store_we;
  logic signed [crse_pkg::PW-1:0] prod;
  logic                      mul_en;
  logic [3:0]                nsteps;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      closed_loop <= 1'b0;
      interp_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crse_pkg::REG_POINT_COUNT: point_count <= cfg_data;
        crse_pkg::REG_CLOSED_LOOP: closed_loop <= cfg_data[0];
        crse_pkg::REG_INTERP_MODE: interp_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_in = (int'(point_count) > crse_pkg::MAX_POINTS) ?
                NW'(crse_pkg::MAX_POINTS) : NW'(point_count);
  assign segs = closed_loop ? n_reg : n_reg - NW'(1);

  // ---------------------------------------------------------------- store
  assign in_acc   = in_valid && in_ready;
  assign eval_acc = in_acc && (func == crse_pkg::FUNC_EVAL);
  assign store_we = in_acc && (func == crse_pkg::FUNC_WRITE) &&
                    (int'(point_index) < crse_pkg::MAX_POINTS);
  assign wdata = '{x: point_x, y: point_y, z: point_z, roll: point_roll};

  crse_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (MW'(point_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // fetch slot: wrap on closed curve, clamp on open one
  always_comb begin
    logic signed [NW+1:0] i;
    logic signed [NW+1:0] nn;
    i  = $signed({2'b00, seg}) - (NW+2)'(1) + $signed((NW+2)'(fk));
    nn = $signed({2'b00, n_reg});
    if (n_reg == NW'(1)) begin
      i = '0;
    end else if (closed_loop) begin
      if (i < 0)        i = i + nn;
      else if (i >= nn) i = i - nn;
    end else begin
      if (i < 0)        i = '0;
      else if (i >= nn) i = nn - (NW+2)'(1);
    end
    raddr = MW'(i);
  end

  // ---------------------------------------------------------------- operands
  function automatic logic signed [OW-1:0] coord(input crse_pkg::point_t p,
                                                 input logic [1:0] a);
    case (a)
      2'd0:    return OW'(p.x);
      2'd1:    return OW'(p.y);
      2'd2:    return OW'(p.z);
      default: return OW'(p.roll);
    endcase
  endfunction

  logic signed [OW-1:0] p0, p1, p2, p3, ca, cb, cc, cd, ce, pr;
  logic signed [OW-1:0] op_next;
  logic                 linear;

  always_comb begin
    p0 = coord(pts[0], ax);
    p1 = coord(pts[1], ax);
    p2 = coord(pts[2], ax);
    p3 = coord(pts[3], ax);
    ca = p2 - p0;
    cb = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    cc = (p1 <<< 1) + p1 - p0 - (p2 <<< 1) - p2 + p3;
    cd = (p0 <<< 2) - (p1 <<< 3) - (p1 <<< 1) + (p2 <<< 3) - (p3 <<< 1);
    ce = (p1 <<< 3) + p1 - (p0 <<< 1) - p0 - (p2 <<< 3) - p2 + (p3 <<< 1) + p3;
    pr = crse_pkg::rnd16(prod);
    linear = (ax == 2'd3) || !interp_mode;
    nsteps = linear ? 4'd2 : 4'd10;
    if (linear) begin
      op_next = p2 - p1;
    end else begin
      case (s[3:1])
        3'd0:    op_next = cc;
        3'd1:    op_next = pr + cb;
        3'd2:    op_next = pr + ca;
        3'd3:    op_next = ce;
        default: op_next = pr + cd;
      endcase
    end
  end

  assign mul_en   = (state == crse_pkg::ST_CALC) && s[0];
  assign calc_fin = (state == crse_pkg::ST_CALC) && (s == nsteps);
  assign emit_go  = (state == crse_pkg::ST_EMIT) && (!out_valid || out_ready);

  crse_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op   (op),
    .t    (lt),
    .prod (prod)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      crse_pkg::ST_IDLE:
        if (eval_acc) state_next = (n_in == '0) ? crse_pkg::ST_EMIT : crse_pkg::ST_SEG;
      crse_pkg::ST_SEG:   state_next = crse_pkg::ST_SPLIT;
      crse_pkg::ST_SPLIT: state_next = crse_pkg::ST_FETCH;
      crse_pkg::ST_FETCH:
        if (fk == 3'd4)
          state_next = (n_reg == NW'(1)) ? crse_pkg::ST_EMIT : crse_pkg::ST_CALC;
      crse_pkg::ST_CALC:
        if (calc_fin && ax == 2'd3) state_next = crse_pkg::ST_EMIT;
      crse_pkg::ST_EMIT:
        if (emit_go) state_next = crse_pkg::ST_IDLE;
      default: state_next = crse_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_ready = (state == crse_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      t_reg <= (curve_t > crse_pkg::T_ONE) ? crse_pkg::T_ONE : curve_t;
      n_reg <= n_in;
      seg   <= '0;
      lt    <= '0;
      fk    <= '0;
    end
    if (state == crse_pkg::ST_SEG) begin
      scaled <= crse_pkg::SC_W'(t_reg) * crse_pkg::SC_W'(segs);
    end
    if (state == crse_pkg::ST_SPLIT && n_reg != NW'(1)) begin
      logic [NW-1:0] sq;
      logic [NW-1:0] sg;
      sq = NW'(scaled >> 16);
      sg = (sq > segs - NW'(1)) ? segs - NW'(1) : sq;
      seg <= sg;
      if (sg == segs - NW'(1) && t_reg >= crse_pkg::T_ONE)
        lt <= crse_pkg::T_ONE;
      else
        lt <= crse_pkg::T_W'(scaled - (crse_pkg::SC_W'(sg) << 16));
    end
    if (state == crse_pkg::ST_FETCH) begin
      fk <= fk + 3'd1;
      if (fk != 3'd0) pts[fk[1:0] - 2'd1] <= rdata;
      ax <= '0;
      s  <= '0;
    end
    if (state == crse_pkg::ST_CALC) begin
      if (calc_fin) begin
        s  <= '0;
        ax <= ax + 2'd1;
        if (ax == 2'd3) begin
          res_roll <= crse_pkg::sat16((OW+1)'(p1) + (OW+1)'(pr));
        end else if (linear) begin
          res_pos[ax] <= crse_pkg::sat32((OW+1)'(p1) + (OW+1)'(pr));
          res_tan[ax] <= crse_pkg::sat32((OW+1)'(p2 - p1));
        end else begin
          res_pos[ax] <= crse_pkg::sat32(crse_pkg::rnd1((OW+1)'(hsave) +
                                          ((OW+1)'(p1) <<< 1)));
          res_tan[ax] <= crse_pkg::sat32(crse_pkg::rnd1((OW+1)'(pr) + (OW+1)'(ca)));
        end
      end else begin
        s <= s + 4'd1;
        if (!s[0]) op <= op_next;
        if (!linear && s == 4'd6) hsave <= pr;
      end
    end
  end

  // ---------------------------------------------------------------- result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      tan_x <= '0; tan_y <= '0; tan_z <= '0;
      roll_out    <= '0;
      segment_out <= '0;
      local_t_out <= '0;
      if (n_reg == '0) begin
        sample_kind <= crse_pkg::KIND_EMPTY;
      end else if (n_reg == NW'(1)) begin
        sample_kind <= crse_pkg::KIND_SINGLE;
        pos_x    <= pts[1].x;
        pos_y    <= pts[1].y;
        pos_z    <= pts[1].z;
        tan_z    <= 32'sd65536;
        roll_out <= pts[1].roll;
      end else begin
        sample_kind <= crse_pkg::KIND_CURVE;
        pos_x <= res_pos[0]; pos_y <= res_pos[1]; pos_z <= res_pos[2];
        tan_x <= res_tan[0]; tan_y <= res_tan[1]; tan_z <= res_tan[2];
        roll_out    <= res_roll;
        segment_out <= 6'(seg);
        local_t_out <= lt;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_busy_after_eval: assert property (@(posedge clk) disable iff (rst)
    eval_acc |=> !in_ready)
    else $error("in_ready stayed high after an evaluate word");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_kind != 2'd3)
    else $error("illegal sample_kind");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_kind == crse_pkg::KIND_EMPTY) |->
      (pos_x == 0 && tan_z == 0 && roll_out == 0))
    else $error("empty sample carries data");

  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == crse_pkg::ST_FETCH) |-> fk <= 3'd4)
    else $error("fetch counter overran");

  a_local_t_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> local_t_out <= crse_pkg::T_ONE)
    else $error("local t above one");

endmodule

// ----- dv/tb_catmull_rom_spline_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// tb_catmull_rom_spline_evaluator_core: self-checking bench for the evaluator
// A queue-fed driver sends write and evaluate words. A predictor keeps its own
// point store and register copy and works out each sample. A monitor checks
// every sample word against the oldest prediction. The run steps through
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_catmull_rom_spline_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               fn;
    logic [5:0]         idx;
    logic signed [31:0] x, y, z;
    logic signed [15:0] roll;
    logic [16:0]        t;
  } word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px, py, pz, tx, ty, tz;
    logic signed [15:0] roll;
    logic [5:0]         seg;
    logic [16:0]        lt;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic func = 1'b0;
  logic [5:0] point_index = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [15:0] point_roll = '0;
  logic [16:0] curve_t = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] sample_kind;
  logic signed [31:0] pos_x, pos_y, pos_z, tan_x, tan_y, tan_z;
  logic signed [15:0] roll_out;
  logic [5:0] segment_out;
  logic [16:0] local_t_out;

  catmull_rom_spline_evaluator_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint mdl_x[64], mdl_y[64], mdl_z[64], mdl_roll[64];
  int unsigned mdl_count = 0;
  bit mdl_closed = 1'b0;
  bit mdl_cubic = 1'b1;

  word_t   word_queue[$];
  sample_t pending_samples[$];
  bit      slot_written[64];
  int      idle_in = 0, idle_out = 0;
  int      hold_req = 0, hold_seen = 0, hold_cnt = 0;
  int      mismatches = 0;
  word_t   cur;

  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint rnd1(longint v);
    return (v + 64'sd1) >>> 1;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic int wrap_slot(longint i, longint n);
    longint r;
    if (mdl_closed) begin
      r = i % n;
      if (r < 0) r += n;
      return int'(r);
    end
    if (i < 0) return 0;
    if (i > n - 1) return int'(n - 1);
    return int'(i);
  endfunction

  // one axis: position and raw tangent
  function automatic void eval_axis(longint p0, longint p1, longint p2, longint p3,
                                    longint t, output longint pos, output longint tng);
    longint a, b, c, d, e, h, g;
    a = p2 - p0;
    if (!mdl_cubic) begin
      pos = clip(p1 + rnd16((p2 - p1) * t), 32);
      tng = clip(p2 - p1, 32);
      return;
    end
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = 3 * p1 - p0 - 3 * p2 + p3;
    d = 4 * p0 - 10 * p1 + 8 * p2 - 2 * p3;
    e = 9 * p1 - 3 * p0 - 9 * p2 + 3 * p3;
    h = rnd16(c * t);
    h = rnd16((h + b) * t);
    h = rnd16((h + a) * t);
    pos = clip(rnd1(h + 2 * p1), 32);
    g = rnd16(e * t);
    g = rnd16((g + d) * t);
    tng = clip(rnd1(g + a), 32);
  endfunction

  // store update or sample prediction for one accepted word
  task automatic predict_sample(input word_t w);
    sample_t s;
    longint n, segs, t, scaled, seg, lt, ps, tg;
    int ix[4];
    if (w.fn == crse_pkg::FUNC_WRITE) begin
      mdl_x[w.idx] = w.x;
      mdl_y[w.idx] = w.y;
      mdl_z[w.idx] = w.z;
      mdl_roll[w.idx] = w.roll;
      return;
    end
    s = '{default: '0};
    n = mdl_count > 64 ? 64 : mdl_count;
    if (n == 1) begin
      s.kind = crse_pkg::KIND_SINGLE;
      s.px = 32'(mdl_x[0]); s.py = 32'(mdl_y[0]); s.pz = 32'(mdl_z[0]);
      s.tz = 32'sd65536;
      s.roll = 16'(mdl_roll[0]);
    end else if (n > 1) begin
      segs = mdl_closed ? n : n - 1;
      t = w.t > 65536 ? 65536 : w.t;
      scaled = t * segs;
      seg = scaled >>> 16;
      if (seg > segs - 1) seg = segs - 1;
      lt = (seg == segs - 1 && t >= 65536) ? 65536 : scaled - seg * 65536;
      for (int k = 0; k < 4; k++) ix[k] = wrap_slot(seg - 1 + k, n);
      s.kind = crse_pkg::KIND_CURVE;
      eval_axis(mdl_x[ix[0]], mdl_x[ix[1]], mdl_x[ix[2]], mdl_x[ix[3]], lt, ps, tg);
      s.px = 32'(ps); s.tx = 32'(tg);
      eval_axis(mdl_y[ix[0]], mdl_y[ix[1]], mdl_y[ix[2]], mdl_y[ix[3]], lt, ps, tg);
      s.py = 32'(ps); s.ty = 32'(tg);
      eval_axis(mdl_z[ix[0]], mdl_z[ix[1]], mdl_z[ix[2]], mdl_z[ix[3]], lt, ps, tg);
      s.pz = 32'(ps); s.tz = 32'(tg);
      s.roll = 16'(clip(mdl_roll[ix[1]] +
                        rnd16((mdl_roll[ix[2]] - mdl_roll[ix[1]]) * lt), 16));
      s.seg = seg[5:0];
      s.lt = lt[16:0];
    end
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // driver: one word in flight, refilled from the queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_sample(cur);
      if (!(in_valid && !in_ready)) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= idle_in) begin
          cur = word_queue.pop_front();
          func <= cur.fn;
          point_index <= cur.idx;
          point_x <= cur.x;
          point_y <= cur.y;
          point_z <= cur.z;
          point_roll <= cur.roll;
          curve_t <= cur.t;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare against oldest prediction, drive out_ready
  always @(posedge clk) begin
    sample_t got, exp;
    if (!rst && out_valid && out_ready) begin
      got = '{sample_kind, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
              roll_out, segment_out, local_t_out};
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample word kind=%0d", sample_kind);
      end else begin
        exp = pending_samples.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample mismatch exp: k=%0d p=%0d %0d %0d t=%0d %0d %0d r=%0d s=%0d l=%0d",
                     exp.kind, exp.px, exp.py, exp.pz, exp.tx, exp.ty, exp.tz,
                     exp.roll, exp.seg, exp.lt);
            $display("                got: k=%0d p=%0d %0d %0d t=%0d %0d %0d r=%0d s=%0d l=%0d",
                     got.kind, got.px, got.py, got.pz, got.tx, got.ty, got.tz,
                     got.roll, got.seg, got.lt);
          end
        end
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_out);
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(input int slot);
    word_t w;
    w.fn = crse_pkg::FUNC_WRITE;
    w.idx = slot[5:0];
    w.x = rand_coord();
    w.y = rand_coord();
    w.z = rand_coord();
    case ($urandom_range(5))
      0: w.roll = 16'sh7FFF;
      1: w.roll = 16'sh8000;
      default: w.roll = 16'($urandom);
    endcase
    w.t = 17'($urandom);
    slot_written[slot] = 1'b1;
    word_queue.insert(word_queue.size(), w);
  endtask

  task automatic push_eval(input logic [16:0] t);
    word_t w;
    w = '{default: '0};
    w.fn = crse_pkg::FUNC_EVAL;
    w.idx = 6'($urandom);
    w.x = $urandom;
    w.t = t;
    word_queue.insert(word_queue.size(), w);
  endtask

  function automatic logic [16:0] rand_t();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return crse_pkg::T_ONE;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // slots below the active count must hold a point before any evaluate
  task automatic fill_slots(input int n);
    for (int i = 0; i < (n > 64 ? 64 : n); i++)
      if (!slot_written[i]) push_write(i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    case (idx)
      crse_pkg::REG_POINT_COUNT: mdl_count = val & 7'h7F;
      crse_pkg::REG_CLOSED_LOOP: mdl_closed = val[0];
      default:                   mdl_cubic = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (word_queue.size() > 0 || in_valid || pending_samples.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(input int n, input bit closed, input bit cubic);
    write_reg(crse_pkg::REG_POINT_COUNT, n);
    write_reg(crse_pkg::REG_CLOSED_LOOP, closed);
    write_reg(crse_pkg::REG_INTERP_MODE, cubic);
  endtask

  initial begin
    int n;
    int counts[10];
    word_t zw;
    counts = '{2, 64, 3, 127, 1, 0, 17, 64, 2, 5};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: empty store, single point, two-point open and closed, linear
    push_eval(crse_pkg::T_ONE);
    drain();
    set_regs(1, 0, 1);
    fill_slots(1);
    push_eval(17'd1000);
    drain();
    set_regs(2, 0, 1);
    fill_slots(2);
    push_eval(17'd0);
    push_eval(17'd32768);
    push_eval(crse_pkg::T_ONE);
    push_eval(17'h1FFFF);
    drain();
    set_regs(2, 1, 1);
    push_eval(17'd0);
    push_eval(17'd40000);
    push_eval(crse_pkg::T_ONE);
    push_eval(17'd65535);
    drain();
    set_regs(2, 0, 0);
    zw = '{crse_pkg::FUNC_WRITE, 6'd1, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 17'd0};
    word_queue.insert(word_queue.size(), zw);
    slot_written[1] = 1'b1;
    push_eval(17'd20000);
    push_eval(crse_pkg::T_ONE);
    drain();

    // random phases
    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        idle_in = 15; idle_out = 63;
      end else if (p < 6) begin
        idle_in = 63; idle_out = 15;
      end else begin
        idle_in = 0; idle_out = 0;
      end
      n = (p == 8) ? $urandom_range(64, 2) : counts[p];
      set_regs(n, 1'($urandom_range(1)), (p % 4 == 3) ? 1'b0 : 1'($urandom_range(1)));
      fill_slots(n);
      for (int i = 0; i < ((n < 2) ? 30 : 130); i++) begin
        if ($urandom_range(3) == 0) push_write($urandom_range(63));
        else push_eval(rand_t());
      end
      if (p == 7) hold_req++;
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
